// ===== rtl/core/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit arena allocator package
// Sizes, table entry layout and result codes shared by the allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int unsigned ARENA_BYTES   = 131072;
  localparam int unsigned HEADER_BYTES  = 12;
  localparam int unsigned GRANULE_BYTES = 16;
  localparam int unsigned MAX_BLOCKS    = 256;

  localparam int unsigned OFF_W   = 17;
  localparam int unsigned BYTES_W = 18;
  localparam int unsigned SZ_W    = 20;
  localparam int unsigned IDX_W   = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W   = IDX_W + 1;
  localparam int unsigned IN_W    = 56;
  localparam int unsigned OUT_W   = 24;

  typedef struct packed {
    logic             free;
    logic [OFF_W-1:0] pay;
    logic [OFF_W-1:0] start;
  } ent_t;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_RELEASE = 2'd1;
  localparam logic [1:0] STAT_OOM     = 2'd2;
  localparam logic [1:0] STAT_UNKNOWN = 2'd3;

endpackage

// ===== rtl/core/first_fit_arena_allocator.sv =====
// ----------------------------------------------------------------------------
// First-fit arena allocator
// Keeps an address-ordered block table in one synchronous memory and serves
// allocate, release, shrink and grow requests by scanning it entry by entry.
// ----------------------------------------------------------------------------
// A null release is answered in the cycle after acceptance; other requests
// scan or move the table one entry per cycle.
// A grow is the longest case: three scans, one shift up and two shift downs.
// One request is served at a time; the next is accepted at the earliest in the
// cycle after the result transaction completes.
// After reset the first table entry is written in ST_INIT before any transaction.
module first_fit_arena_allocator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // pointer_offset[16:0], old_bytes[34:17], new_bytes[52:35], zero fill
  input  logic [ffa_pkg::IN_W-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // result_offset[16:0], status[18:17], copy_needed[19], zero fill
  output logic [ffa_pkg::OUT_W-1:0] m_axis_tdata
);
  import ffa_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_SCAN, ST_SHUP, ST_SPLIT_HI, ST_SPLIT_LO,
    ST_REL_NEXT, ST_REL_NCHK, ST_REL_PREV, ST_REL_PCHK, ST_REL_WR,
    ST_SHDN, ST_DONE
  } state_e;

  typedef enum logic [1:0] {M_FIND, M_ALLOC, M_REFIND} mode_e;

  localparam logic [OFF_W-1:0] HDR  = OFF_W'(HEADER_BYTES);
  localparam logic [SZ_W-1:0]  HDRZ = SZ_W'(HEADER_BYTES);
  localparam logic [SZ_W-1:0]  SPLT = SZ_W'(HEADER_BYTES + GRANULE_BYTES);

  ent_t mem_q [MAX_BLOCKS];
  ent_t rd_q;

  state_e state_q, state_d, ret_q, ret_d;
  mode_e  mode_q, mode_d;
  logic [CNT_W-1:0] total_q, total_d, sc_q, sc_d;
  logic [IDX_W-1:0] cur_q, cur_d, hit_q, hit_d;
  logic             pend_q, pend_d, rel_q, rel_d, shr_q, shr_d, grow_q, grow_d;
  logic [OFF_W-1:0] ptr_q, ptr_d, hst_q, hst_d, hpay_q, hpay_d, cpay_q, cpay_d;
  logic [OFF_W-1:0] res_q, res_d;
  logic [SZ_W-1:0]  size_q, size_d;
  logic [1:0]       stat_q, stat_d;
  logic             copy_q, copy_d, ov_q, ov_d;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  ent_t             wr_data;
  logic             hit_m;

  logic [OFF_W-1:0]   in_ptr;
  logic [BYTES_W-1:0] in_old, in_new;

  assign in_ptr = s_axis_tdata[16:0];
  assign in_old = s_axis_tdata[34:17];
  assign in_new = s_axis_tdata[52:35];

  assign s_axis_tready = (state_q == ST_IDLE) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'd0, copy_q, stat_q, res_q};

  always_comb begin
    if (mode_q == M_ALLOC) begin
      hit_m = rd_q.free && ({3'd0, rd_q.pay} >= size_q);
    end else begin
      hit_m = !rd_q.free && ((SZ_W'(rd_q.start) + HDRZ) == SZ_W'(ptr_q));
    end
  end

  always_comb begin
    state_d = state_q; ret_d = ret_q; mode_d = mode_q;
    total_d = total_q; sc_d = sc_q; cur_d = cur_q; hit_d = hit_q;
    pend_d = pend_q; rel_d = rel_q; shr_d = shr_q; grow_d = grow_q;
    ptr_d = ptr_q; hst_d = hst_q; hpay_d = hpay_q; cpay_d = cpay_q;
    res_d = res_q; size_d = size_q; stat_d = stat_q; copy_d = copy_q;
    ov_d = ov_q && !m_axis_tready;
    wr_en = 1'b0; wr_addr = '0; wr_data = '0; rd_addr = '0;
    case (state_q)
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_data = '{free: 1'b1, pay: OFF_W'(ARENA_BYTES - HEADER_BYTES), start: '0};
        total_d = CNT_W'(1);
        state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          ptr_d  = in_ptr;
          rel_d  = (in_new == '0);
          shr_d  = (in_new <= in_old);
          grow_d = 1'b0;
          copy_d = 1'b0;
          res_d  = '0;
          size_d = SZ_W'(((SZ_W'(in_new) + SZ_W'(GRANULE_BYTES - 1)) / GRANULE_BYTES)
                   * GRANULE_BYTES);
          sc_d   = '0;
          pend_d = 1'b0;
          if (in_ptr == '0 && in_new == '0) begin
            stat_d = STAT_RELEASE;
            ov_d   = 1'b1;
          end else begin
            mode_d  = (in_ptr == '0) ? M_ALLOC : M_FIND;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (pend_q && hit_m) begin
          hit_d  = cur_q;
          hst_d  = rd_q.start;
          hpay_d = rd_q.pay;
          cpay_d = rd_q.pay;
          pend_d = 1'b0;
          case (mode_q)
            M_ALLOC: begin
              if (total_q < CNT_W'(MAX_BLOCKS) && {3'd0, rd_q.pay} >= size_q + SPLT) begin
                sc_d    = total_q - CNT_W'(1);
                state_d = ST_SHUP;
              end else begin
                wr_en   = 1'b1;
                wr_addr = cur_q;
                wr_data = '{free: 1'b0, pay: rd_q.pay, start: rd_q.start};
                res_d   = rd_q.start + HDR;
                stat_d  = STAT_OK;
                if (grow_q) begin
                  copy_d = 1'b1;
                  mode_d = M_REFIND;
                  sc_d   = '0;
                end else begin
                  state_d = ST_DONE;
                end
              end
            end
            M_FIND: begin
              if (rel_q) begin
                stat_d  = STAT_RELEASE;
                state_d = ST_REL_NEXT;
              end else if (shr_q) begin
                res_d   = ptr_q;
                stat_d  = STAT_OK;
                state_d = ST_DONE;
              end else begin
                grow_d = 1'b1;
                mode_d = M_ALLOC;
                sc_d   = '0;
              end
            end
            default: state_d = ST_REL_NEXT;
          endcase
        end else if (sc_q < total_q) begin
          rd_addr = sc_q[IDX_W-1:0];
          cur_d   = sc_q[IDX_W-1:0];
          sc_d    = sc_q + CNT_W'(1);
          pend_d  = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = ST_DONE;
          case (mode_q)
            M_ALLOC: begin
              res_d  = '0;
              stat_d = STAT_OOM;
              copy_d = 1'b0;
            end
            M_FIND: begin
              res_d  = '0;
              stat_d = STAT_UNKNOWN;
            end
            default: ;
          endcase
        end
      end
      ST_SHUP: begin
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_addr = cur_q;
          wr_data = rd_q;
        end
        if (sc_q > {1'b0, hit_q}) begin
          rd_addr = sc_q[IDX_W-1:0];
          cur_d   = sc_q[IDX_W-1:0] + IDX_W'(1);
          sc_d    = sc_q - CNT_W'(1);
          pend_d  = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = ST_SPLIT_HI;
        end
      end
      ST_SPLIT_HI: begin
        wr_en   = 1'b1;
        wr_addr = hit_q + IDX_W'(1);
        wr_data = '{free: 1'b1,
                    pay: OFF_W'(SZ_W'(hpay_q) - size_q - HDRZ),
                    start: OFF_W'(SZ_W'(hst_q) + HDRZ + size_q)};
        state_d = ST_SPLIT_LO;
      end
      ST_SPLIT_LO: begin
        wr_en   = 1'b1;
        wr_addr = hit_q;
        wr_data = '{free: 1'b0, pay: OFF_W'(size_q), start: hst_q};
        total_d = total_q + CNT_W'(1);
        res_d   = hst_q + HDR;
        stat_d  = STAT_OK;
        if (grow_q) begin
          copy_d  = 1'b1;
          mode_d  = M_REFIND;
          sc_d    = '0;
          pend_d  = 1'b0;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_REL_NEXT: begin
        if ({1'b0, hit_q} + CNT_W'(1) < total_q) begin
          rd_addr = hit_q + IDX_W'(1);
          state_d = ST_REL_NCHK;
        end else begin
          state_d = ST_REL_PREV;
        end
      end
      ST_REL_NCHK: begin
        if (rd_q.free) begin
          cpay_d  = cpay_q + HDR + rd_q.pay;
          sc_d    = {1'b0, hit_q} + CNT_W'(2);
          pend_d  = 1'b0;
          ret_d   = ST_REL_PREV;
          state_d = ST_SHDN;
        end else begin
          state_d = ST_REL_PREV;
        end
      end
      ST_REL_PREV: begin
        if (hit_q != '0) begin
          rd_addr = hit_q - IDX_W'(1);
          state_d = ST_REL_PCHK;
        end else begin
          state_d = ST_REL_WR;
        end
      end
      ST_REL_PCHK: begin
        if (rd_q.free) begin
          wr_en   = 1'b1;
          wr_addr = hit_q - IDX_W'(1);
          wr_data = '{free: 1'b1, pay: rd_q.pay + HDR + cpay_q, start: rd_q.start};
          sc_d    = {1'b0, hit_q} + CNT_W'(1);
          pend_d  = 1'b0;
          ret_d   = ST_DONE;
          state_d = ST_SHDN;
        end else begin
          state_d = ST_REL_WR;
        end
      end
      ST_REL_WR: begin
        wr_en   = 1'b1;
        wr_addr = hit_q;
        wr_data = '{free: 1'b1, pay: cpay_q, start: hst_q};
        state_d = ST_DONE;
      end
      ST_SHDN: begin
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_addr = cur_q;
          wr_data = rd_q;
        end
        if (sc_q < total_q) begin
          rd_addr = sc_q[IDX_W-1:0];
          cur_d   = sc_q[IDX_W-1:0] - IDX_W'(1);
          sc_d    = sc_q + CNT_W'(1);
          pend_d  = 1'b1;
        end else begin
          pend_d  = 1'b0;
          if (total_q > CNT_W'(1)) begin
            total_d = total_q - CNT_W'(1);
          end
          state_d = ret_q;
        end
      end
      ST_DONE: begin
        ov_d    = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      ret_q   <= ST_DONE;
      mode_q  <= M_FIND;
      total_q <= CNT_W'(1);
      sc_q    <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      mode_q  <= mode_d;
      total_q <= total_d;
      sc_q    <= sc_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    hit_q  <= hit_d;
    rel_q  <= rel_d;
    shr_q  <= shr_d;
    grow_q <= grow_d;
    ptr_q  <= ptr_d;
    hst_q  <= hst_d;
    hpay_q <= hpay_d;
    cpay_q <= cpay_d;
    res_q  <= res_d;
    size_q <= size_d;
    stat_q <= stat_d;
    copy_q <= copy_d;
  end

`ifndef NO_ASSERTIONS
  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q >= CNT_W'(1)) && (total_q <= CNT_W'(MAX_BLOCKS)))
    else $error("block count out of range");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != $past(total_q)) |->
      (total_q == $past(total_q) + CNT_W'(1)) || (total_q == $past(total_q) - CNT_W'(1)))
    else $error("block count moved by more than one");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !wr_en)
    else $error("table written while idle");

  a_copy_only_granted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && copy_q) |-> (stat_q == STAT_OK))
    else $error("copy flagged on a refused request");
`endif

endmodule

// ===== sim/tb_first_fit_arena_allocator.sv =====
// ----------------------------------------------------------------------------
// First-fit arena allocator testbench
// Directed and random allocate, release, shrink and grow requests are driven
// with idle bursts on both streams. Each result is checked in order against a
// behavioural copy of the block table.
// ----------------------------------------------------------------------------
module tb_first_fit_arena_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import ffa_pkg::*;

  typedef struct {
    bit [16:0] ptr;
    bit [17:0] old_b;
    bit [17:0] new_b;
    bit        hold;
  } req_t;

  typedef struct {
    bit [16:0] off;
    bit [1:0]  st;
    bit        cp;
  } rsp_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  first_fit_arena_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Shadow block table.
  int unsigned tbl_start [MAX_BLOCKS];
  int unsigned tbl_pay   [MAX_BLOCKS];
  bit          tbl_free  [MAX_BLOCKS];
  int unsigned tbl_total;

  req_t        pending_reqs[$];
  rsp_t        expected_rsps[$];
  int unsigned live_off[$];
  int unsigned live_len[$];
  int unsigned sent_cnt = 0, recv_cnt = 0, fail_cnt = 0, idle_cycles = 0;
  int unsigned stat_seen[4];
  int unsigned peak_blocks = 1;
  bit          quiet_tail = 1'b0;

  function automatic int find_alloc(int unsigned off);
    for (int i = 0; i < tbl_total; i++)
      if (!tbl_free[i] && tbl_start[i] + HEADER_BYTES == off) return i;
    return -1;
  endfunction

  function automatic void drop_entry(int unsigned j);
    for (int unsigned m = j; m + 1 < tbl_total; m++) begin
      tbl_start[m] = tbl_start[m+1];
      tbl_pay[m]   = tbl_pay[m+1];
      tbl_free[m]  = tbl_free[m+1];
    end
    if (tbl_total > 1) tbl_total--;
  endfunction

  function automatic void free_entry(int unsigned k);
    tbl_free[k] = 1'b1;
    if (k + 1 < tbl_total && tbl_free[k+1]) begin
      tbl_pay[k] += HEADER_BYTES + tbl_pay[k+1];
      drop_entry(k + 1);
    end
    if (k > 0 && tbl_free[k-1]) begin
      tbl_pay[k-1] += HEADER_BYTES + tbl_pay[k];
      drop_entry(k);
    end
  endfunction

  function automatic int unsigned take_first_fit(int unsigned bytes);
    int unsigned size;
    size = ((bytes + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
    for (int unsigned i = 0; i < tbl_total; i++) begin
      if (!tbl_free[i] || tbl_pay[i] < size) continue;
      if (tbl_total < MAX_BLOCKS && tbl_pay[i] >= size + HEADER_BYTES + GRANULE_BYTES) begin
        for (int unsigned m = tbl_total; m > i + 1; m--) begin
          tbl_start[m] = tbl_start[m-1];
          tbl_pay[m]   = tbl_pay[m-1];
          tbl_free[m]  = tbl_free[m-1];
        end
        tbl_start[i+1] = tbl_start[i] + HEADER_BYTES + size;
        tbl_pay[i+1]   = tbl_pay[i] - size - HEADER_BYTES;
        tbl_free[i+1]  = 1'b1;
        tbl_pay[i]     = size;
        tbl_total++;
      end
      tbl_free[i] = 1'b0;
      return tbl_start[i] + HEADER_BYTES;
    end
    return 0;
  endfunction

  function automatic rsp_t serve_request(req_t r);
    rsp_t o;
    int   k;
    o = '{off: 17'd0, st: STAT_OK, cp: 1'b0};
    if (r.ptr == 0) begin
      if (r.new_b == 0) o.st = STAT_RELEASE;
      else begin
        o.off = 17'(take_first_fit(r.new_b));
        o.st  = (o.off != 0) ? STAT_OK : STAT_OOM;
      end
    end else begin
      k = find_alloc(r.ptr);
      if (k < 0) o.st = STAT_UNKNOWN;
      else if (r.new_b == 0) begin
        free_entry(k);
        o.st = STAT_RELEASE;
      end else if (r.new_b <= r.old_b) o.off = r.ptr;
      else begin
        o.off = 17'(take_first_fit(r.new_b));
        if (o.off == 0) o.st = STAT_OOM;
        else begin
          k = find_alloc(r.ptr);
          if (k >= 0) free_entry(k);
          o.cp = 1'b1;
        end
      end
    end
    return o;
  endfunction

  // Queues a request, predicts its result and keeps the list of live
  // allocations up to date so later requests can name real pointers.
  task automatic queue_req(int unsigned ptr, int unsigned old_b, int unsigned new_b,
                           bit hold = 1'b0);
    req_t r;
    rsp_t o;
    r = '{ptr: 17'(ptr), old_b: 18'(old_b), new_b: 18'(new_b), hold: hold};
    o = serve_request(r);
    pending_reqs.push_back(r);
    expected_rsps.push_back(o);
    if (tbl_total > peak_blocks) peak_blocks = tbl_total;
    if (o.st == STAT_RELEASE || (o.st == STAT_OK && o.cp)) begin
      foreach (live_off[i])
        if (live_off[i] == ptr) begin
          live_off.delete(i);
          live_len.delete(i);
          break;
        end
    end
    if (o.st == STAT_OK && (ptr == 0 || o.cp)) begin
      live_off.push_back(o.off);
      live_len.push_back(new_b);
    end
  endtask

  function automatic int unsigned pick_size();
    int unsigned d;
    d = $urandom_range(0, 99);
    if (d < 70) return $urandom_range(1, 256);
    if (d < 95) return $urandom_range(1, 4096);
    return $urandom_range(1, 131072);
  endfunction

  task automatic random_req(int unsigned alloc_pct);
    int unsigned d, j;
    d = $urandom_range(0, 99);
    if (live_off.size() == 0 || d < alloc_pct) begin
      queue_req(0, $urandom_range(0, 131072), pick_size());
    end else if (d < 92) begin
      j = $urandom_range(0, live_off.size() - 1);
      case ($urandom_range(0, 2))
        0: queue_req(live_off[j], live_len[j], 0);
        1: queue_req(live_off[j], live_len[j], $urandom_range(1, live_len[j]));
        default: queue_req(live_off[j], live_len[j], live_len[j] + pick_size());
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0: queue_req($urandom_range(0, 131071), $urandom_range(0, 131072),
                     $urandom_range(0, 131072));
        1: queue_req($urandom_range(1, 131071) | 17'h1, 0, 0);
        2: queue_req(0, 0, 0);
        default: queue_req(0, $urandom_range(0, 131072), $urandom_range(120000, 131072));
      endcase
    end
  endtask

  // Stimulus.
  initial begin
    int unsigned a, b, c;
    tbl_total = 1;
    tbl_start[0] = 0;
    tbl_pay[0] = ARENA_BYTES - HEADER_BYTES;
    tbl_free[0] = 1'b1;
    foreach (stat_seen[i]) stat_seen[i] = 0;

    queue_req(0, 0, 0);
    queue_req(0, 131072, 131072);
    queue_req(17'h1FFFF, 131072, 0);
    queue_req(12, 16, 16);
    queue_req(0, 0, 1);
    a = expected_rsps[$].off;
    queue_req(0, 0, 16);
    b = expected_rsps[$].off;
    queue_req(0, 0, 17);
    c = expected_rsps[$].off;
    queue_req(0, 0, 100);
    queue_req(b, 16, 8);
    queue_req(b, 16, 16);
    queue_req(a, 0, 0);
    queue_req(c, 17, 0);
    queue_req(b, 16, 0);
    queue_req(b, 16, 0);
    queue_req(0, 0, 131060);
    queue_req(live_off[0], live_len[0], 5000);
    queue_req(live_off[0], live_len[0], 131072);
    queue_req(live_off[0], 131072, 131072);
    queue_req(live_off[0], 0, 0);
    queue_req(0, 0, 131060, 1'b1);
    queue_req(expected_rsps[$].off, 131060, 0);

    for (int n = 0; n < 1500; n++) begin
      if (n == 400 || n == 1000) queue_req(0, 0, 0, 1'b1);
      random_req((n % 500) < 300 ? 80 : 25);
    end
    while (live_off.size() != 0) queue_req(live_off[0], live_len[0], 0);
    queue_req(0, 0, 131060);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_reqs.size() < 150);
    quiet_tail = 1'b1;
    wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
    repeat (800) @(posedge clk_i);
    $display("Checked %0d results: %0d granted, %0d released, %0d out of memory, %0d unknown.",
             recv_cnt, stat_seen[0], stat_seen[1], stat_seen[2], stat_seen[3]);
    $display("Block table peaked at %0d entries; %0d mismatches.", peak_blocks, fail_cnt);
    if (fail_cnt == 0 && expected_rsps.size() == 0) begin
      $display("first_fit_arena_allocator regression: pass");
    end else begin
      $display("first_fit_arena_allocator regression: fail");
    end
    $finish;
  end

  // Driver.
  bit          in_fire = 1'b0;
  int unsigned src_gap = 0, sink_gap = 0;

  always @(posedge clk_i) begin
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) sent_cnt <= sent_cnt + 1;
  end

  always @(negedge clk_i) begin
    logic v;
    req_t r;
    v = s_axis_tvalid;
    if (in_fire) v = 1'b0;
    if (rst_ni && !v) begin
      if (src_gap > 0) src_gap--;
      else if (pending_reqs.size() != 0 &&
               (!pending_reqs[0].hold || recv_cnt == sent_cnt)) begin
        r = pending_reqs.pop_front();
        s_axis_tdata <= {3'b0, r.new_b, r.old_b, r.ptr};
        v = 1'b1;
        if (!quiet_tail && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 8);
      end
    end
    s_axis_tvalid <= v;
    if (!rst_ni || quiet_tail) m_axis_tready <= 1'b1;
    else if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= (sink_gap == 0);
    end else if ($urandom_range(0, 5) == 0) begin
      sink_gap = $urandom_range(1, 8);
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= 1'b1;
  end

  // Monitor.
  always @(posedge clk_i) begin
    rsp_t e, got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.off = m_axis_tdata[16:0];
      got.st  = m_axis_tdata[18:17];
      got.cp  = m_axis_tdata[19];
      recv_cnt <= recv_cnt + 1;
      stat_seen[got.st]++;
      if (expected_rsps.size() == 0) begin
        $display("%0t: result with none expected: offset %0d status %0d copy %0d",
                 $realtime, got.off, got.st, got.cp);
        fail_cnt++;
      end else begin
        e = expected_rsps.pop_front();
        if (e.off != got.off || e.st != got.st || e.cp != got.cp) begin
          $display("%0t: mismatch: expected offset %0d status %0d copy %0d, got %0d %0d %0d",
                   $realtime, e.off, e.st, e.cp, got.off, got.st, got.cp);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pending_reqs.size() == 0 && expected_rsps.size() == 0)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 20000) begin
      $display("%0t: no transaction for %0d cycles", $realtime, idle_cycles);
      $display("first_fit_arena_allocator regression: fail");
      $finish;
    end
  end

endmodule
